/* sv/vnu_pkg.sv */
`timescale 1ns / 1ps
package vnu_pkg;

  localparam int COMP_W    = 32;  // width of one vector component
  localparam int NUM_COMP  = 3;   // x, y, z
  localparam int SQ_W      = 64;  // squared length
  localparam int ROOT_W    = 32;  // floor square root of SQ_W bits
  localparam int SREM_W    = 34;  // square-root partial remainder
  localparam int DEF_OUT_FRAC_BITS = 30;

  // Sideband carried along the square-root chain.
  typedef struct packed {
    logic [NUM_COMP-1:0][COMP_W-1:0] mag;
    logic [NUM_COMP-1:0]             neg;
    logic                            zero;
  } side_t;

endpackage

/* sv/vnu_sqrt_cell.sv */
`timescale 1ns / 1ps
module vnu_sqrt_cell (
  input  logic                        clk,
  input  logic                        en,
  input  logic [vnu_pkg::SQ_W-1:0]    rad_i,
  input  logic [vnu_pkg::SREM_W-1:0]  rem_i,
  input  logic [vnu_pkg::ROOT_W-1:0]  root_i,
  input  vnu_pkg::side_t              side_i,
  output logic [vnu_pkg::SQ_W-1:0]    rad_o,
  output logic [vnu_pkg::SREM_W-1:0]  rem_o,
  output logic [vnu_pkg::ROOT_W-1:0]  root_o,
  output vnu_pkg::side_t              side_o
);
  import vnu_pkg::*;

  logic [SREM_W+1:0] trial;
  logic [SREM_W+1:0] test;
  logic              ge;

  // One root bit: bring down the next two radicand bits, try 4r+1.
  always_comb begin
    trial = {rem_i, rad_i[SQ_W-1 -: 2]};
    test  = {2'b00, root_i, 2'b01};
    ge    = (trial >= test);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_o  <= {rad_i[SQ_W-3:0], 2'b00};
      rem_o  <= ge ? SREM_W'(trial - test) : SREM_W'(trial);
      root_o <= {root_i[ROOT_W-2:0], ge};
      side_o <= side_i;
    end
  end

endmodule

/* sv/vnu_div_cell.sv */
`timescale 1ns / 1ps
module vnu_div_cell #(
  parameter int QB = vnu_pkg::DEF_OUT_FRAC_BITS + 1
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [vnu_pkg::ROOT_W-1:0]  rem_i,
  input  logic                        bit_i,
  input  logic [QB-1:0]               q_i,
  input  logic [vnu_pkg::ROOT_W-1:0]  len_i,
  input  logic                        neg_i,
  output logic [vnu_pkg::ROOT_W-1:0]  rem_o,
  output logic [QB-1:0]               q_o,
  output logic [vnu_pkg::ROOT_W-1:0]  len_o,
  output logic                        neg_o
);
  import vnu_pkg::*;

  logic [ROOT_W:0] t;
  logic            ge;

  // One restoring quotient bit.
  always_comb begin
    t  = {rem_i, bit_i};
    ge = (t >= {1'b0, len_i});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= ge ? ROOT_W'(t - {1'b0, len_i}) : ROOT_W'(t);
      q_o   <= {q_i[QB-2:0], ge};
      len_o <= len_i;
      neg_o <= neg_i;
    end
  end

endmodule

/* sv/vector3_normalise_unit.sv */
`timescale 1ns / 1ps
// Channel | Direction | tdata (low bit up)       | tuser        | tlast
// in_     | slave     | in_x, in_y, in_z (96b)   | -            | -
// out_    | master    | unit_x, unit_y, unit_z   | zero_length  | -
//
// Throughput: one item per cycle when the output is not stalled; stages are 4 front
// stages, 32 square-root cells, OUT_FRAC_BITS+1 divide cells and the output
// register.
// Reset: rst_n synchronous, clears the stage valid bits only.
// Stalls: the whole chain advances together; it holds when the output
// register has an item that the sink does not take.
module vector3_normalise_unit #(
  parameter int OUT_FRAC_BITS = vnu_pkg::DEF_OUT_FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // in_x [31:0], in_y [63:32], in_z [95:64]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // unit_x [31:0], unit_y [63:32], unit_z [95:64]
  output logic         out_tuser   // zero_length
);
  import vnu_pkg::*;

  localparam int QB  = OUT_FRAC_BITS + 1;        // quotient bits
  localparam int NST = 4 + ROOT_W + QB + 1;      // stages incl. output reg

  logic           en;
  logic [NST-1:0] vld_r;

  // Advance whenever the output register is empty or being drained.
  assign en        = !vld_r[NST-1] || out_tready;
  assign in_tready = en;
  assign out_tvalid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_tvalid};
    end
  end

  // ---- front: magnitudes, squares, two-step sum ----
  side_t side1_r, side2_r, side3_r, side4_r;
  side_t side_c;
  logic [NUM_COMP-1:0][SQ_W-1:0] sq_r;
  logic [SQ_W-1:0] psum_r, sq2_r, sum_r;

  always_comb begin
    side_c = '0;
    for (int i = 0; i < NUM_COMP; i++) begin
      side_c.neg[i] = in_tdata[i*COMP_W + COMP_W-1];
      side_c.mag[i] = side_c.neg[i] ? (~in_tdata[i*COMP_W +: COMP_W] + COMP_W'(1))
                                    : in_tdata[i*COMP_W +: COMP_W];
    end
    side_c.zero = (in_tdata == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= side_c;
      for (int i = 0; i < NUM_COMP; i++) begin
        sq_r[i] <= SQ_W'(side1_r.mag[i]) * SQ_W'(side1_r.mag[i]);
      end
      side2_r <= side1_r;
      psum_r  <= sq_r[0] + sq_r[1];
      sq2_r   <= sq_r[2];
      side3_r <= side2_r;
      sum_r   <= psum_r + sq2_r;
      side4_r <= side3_r;
    end
  end

  // ---- square-root chain: one root bit per cell ----
  logic [SQ_W-1:0]   rad  [0:ROOT_W];
  logic [SREM_W-1:0] srem [0:ROOT_W];
  logic [ROOT_W-1:0] root [0:ROOT_W];
  side_t             side [0:ROOT_W];

  assign rad[0]  = sum_r;
  assign srem[0] = '0;
  assign root[0] = '0;
  assign side[0] = side4_r;

  for (genvar s = 0; s < ROOT_W; s++) begin : g_sqrt
    vnu_sqrt_cell u_cell (
      .clk    (clk),
      .en     (en),
      .rad_i  (rad[s]),
      .rem_i  (srem[s]),
      .root_i (root[s]),
      .side_i (side[s]),
      .rad_o  (rad[s+1]),
      .rem_o  (srem[s+1]),
      .root_o (root[s+1]),
      .side_o (side[s+1])
    );
  end

  // ---- divide chain: one quotient bit per cell, three lanes ----
  logic [ROOT_W-1:0] drem [NUM_COMP][0:QB];
  logic [QB-1:0]     dq   [NUM_COMP][0:QB];
  logic [ROOT_W-1:0] dlen [NUM_COMP][0:QB];
  logic              dneg [NUM_COMP][0:QB];
  logic              zl_r [1:QB];

  // Carry the zero-length flag alongside the divide cells.
  always_ff @(posedge clk) begin
    if (en) begin
      zl_r[1] <= side[ROOT_W].zero;
      for (int s = 1; s < QB; s++) zl_r[s+1] <= zl_r[s];
    end
  end

  for (genvar l = 0; l < NUM_COMP; l++) begin : g_lane
    // Remainder starts at mag/2; mag's low bit is the first bit brought down.
    assign drem[l][0] = {1'b0, side[ROOT_W].mag[l][COMP_W-1:1]};
    assign dq[l][0]   = '0;
    assign dlen[l][0] = root[ROOT_W];
    assign dneg[l][0] = side[ROOT_W].neg[l];
    for (genvar s = 0; s < QB; s++) begin : g_div
      vnu_div_cell #(.QB(QB)) u_cell (
        .clk   (clk),
        .en    (en),
        .rem_i (drem[l][s]),
        .bit_i ((s == 0) ? side[ROOT_W].mag[l][0] : 1'b0),
        .q_i   (dq[l][s]),
        .len_i (dlen[l][s]),
        .neg_i (dneg[l][s]),
        .rem_o (drem[l][s+1]),
        .q_o   (dq[l][s+1]),
        .len_o (dlen[l][s+1]),
        .neg_o (dneg[l][s+1])
      );
    end
  end

  // ---- output register: apply sign, force zero vector ----
  logic [NUM_COMP-1:0][COMP_W-1:0] unit_nxt;
  logic [NUM_COMP-1:0][COMP_W-1:0] unit_r;
  logic                            zero_r;

  always_comb begin
    for (int l = 0; l < NUM_COMP; l++) begin
      unit_nxt[l] = dneg[l][QB] ? (COMP_W'(0) - COMP_W'(dq[l][QB])) : COMP_W'(dq[l][QB]);
      if (zl_r[QB]) unit_nxt[l] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit_r <= unit_nxt;
      zero_r <= zl_r[QB];
    end
  end

  assign out_tdata = unit_r;
  assign out_tuser = zero_r;

  // ---- checks ----
  localparam logic signed [COMP_W-1:0] UNIT_ONE = COMP_W'(64'd1 << OUT_FRAC_BITS);

  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("zero-length item with nonzero data");

  a_range_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[31:0]) <= UNIT_ONE) &&
                   ($signed(out_tdata[31:0]) >= -UNIT_ONE))
    else $error("unit_x beyond 1.0");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("chain advance mismatch");

endmodule
